/* hw/rtl/qfm_pkg.sv */
// Shared types and constants for the binary128 multiplier.
`default_nettype none
package qfm_pkg;

  localparam int unsigned SIG_W   = 113;
  localparam int unsigned PROD_W  = 226;
  localparam int unsigned LIMB_W  = 32;
  localparam int unsigned NLIMB   = 4;
  localparam int unsigned NCELL   = NLIMB * NLIMB;
  localparam int unsigned EXP_W   = 15;
  localparam int unsigned FRAC_W  = 112;

  localparam logic [EXP_W-1:0] EXP_BIAS = 15'h3FFF;
  localparam logic [EXP_W-1:0] EXP_MAX  = 15'h7FFF;

  typedef struct packed {
    logic              valid;
    logic              sgn;
    logic              zero;
    logic [EXP_W:0]    esum;
    logic [SIG_W-1:0]  sa;
    logic [SIG_W-1:0]  sb;
    logic [PROD_W-1:0] acc;
  } stage_t;

  typedef struct packed {
    logic [63:0] product_high;
    logic [63:0] product_low;
    logic        overflow_flag;
    logic        underflow_flag;
  } result_t;

endpackage
`default_nettype wire

/* hw/rtl/qfm_cell.sv */
// One multiply-accumulate cell: adds a single 32x32 limb product into the running product.
`default_nettype none
module qfm_cell #(
  parameter int unsigned LIMB_A = 0,
  parameter int unsigned LIMB_B = 0
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire qfm_pkg::stage_t stage_in,
  output qfm_pkg::stage_t     stage_out
);

  logic [127:0] sa_ext;
  logic [127:0] sb_ext;
  logic [31:0]  la;
  logic [31:0]  lb;
  logic [63:0]  pp;
  logic [qfm_pkg::PROD_W-1:0] pp_sh;
  qfm_pkg::stage_t nxt;
  logic valid_r;
  qfm_pkg::stage_t data_r;

  assign sa_ext = {15'd0, stage_in.sa};
  assign sb_ext = {15'd0, stage_in.sb};
  assign la     = sa_ext[LIMB_A*32 +: 32];
  assign lb     = sb_ext[LIMB_B*32 +: 32];
  assign pp     = {32'd0, la} * {32'd0, lb};
  assign pp_sh  = {{(qfm_pkg::PROD_W-64){1'b0}}, pp} << (32 * (LIMB_A + LIMB_B));

  always_comb begin
    nxt     = stage_in;
    nxt.acc = stage_in.acc + pp_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= stage_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= nxt;
    end
  end

  always_comb begin
    stage_out       = data_r;
    stage_out.valid = valid_r;
  end

endmodule
`default_nettype wire

/* hw/rtl/qfm_norm.sv */
// Final cell: normalizes, truncates and packs the product, with overflow and underflow handling.
`default_nettype none
module qfm_norm (
  input  wire qfm_pkg::stage_t stage_in,
  output qfm_pkg::result_t    res
);

  logic                       top;
  logic signed [17:0]         exc;
  logic [qfm_pkg::PROD_W-1:0] shifted;

  assign top     = stage_in.acc[qfm_pkg::PROD_W-1];
  assign exc     = $signed({2'b00, stage_in.esum}) - $signed({3'b000, qfm_pkg::EXP_BIAS})
                 + $signed({17'd0, top});
  assign shifted = stage_in.acc >> (qfm_pkg::FRAC_W + {7'd0, top});

  always_comb begin
    res = '0;
    res.product_high[63] = stage_in.sgn;
    if (stage_in.zero) begin
      res.product_low = '0;
    end else if (exc >= $signed({3'b000, qfm_pkg::EXP_MAX})) begin
      res.product_high[62:48] = qfm_pkg::EXP_MAX;
      res.overflow_flag       = 1'b1;
    end else if (exc <= 18'sd0) begin
      res.underflow_flag = 1'b1;
    end else begin
      res.product_high[62:48] = exc[14:0];
      res.product_high[47:0]  = shifted[111:64];
      res.product_low         = shifted[63:0];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/quad_float_multiply.sv */
// Top level of the pipelined binary128 multiplier built from a chain of limb cells.
//
// The input channel carries one operand pair per transaction on in_tdata:
// a_high, a_low, b_high, b_low from the lowest bit up. The output channel
// carries the product on out_tdata (product_high, product_low) and the
// overflow and underflow flags on out_tuser.
// Sixteen cells each add one 32x32 limb product into the running 226-bit
// product and pass it on to the next cell whenever the chain advances; a
// final stage normalizes and packs the result into the output register.
// Throughput is one operand pair per cycle unless the receiver stalls,
// set by the single multiplier in each cell.
// The whole chain advances together; when the receiver stalls with a result
// waiting, the chain and in_tready hold until that result is taken.
// Reset clears all valid bits; no result is pending after reset.
`default_nettype none
module quad_float_multiply (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [255:0] in_tdata,   // a_high, a_low, b_high, b_low
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata,  // product_high, product_low
  output logic [1:0]        out_tuser   // overflow_flag, underflow_flag
);

  logic advance;
  qfm_pkg::stage_t  chain [0:qfm_pkg::NCELL];
  qfm_pkg::result_t res;
  qfm_pkg::result_t res_r;
  logic             out_valid_r;
  logic [63:0]      ah;
  logic [63:0]      al;
  logic [63:0]      bh;
  logic [63:0]      bl;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = advance;

  assign ah = in_tdata[63:0];
  assign al = in_tdata[127:64];
  assign bh = in_tdata[191:128];
  assign bl = in_tdata[255:192];

  always_comb begin
    chain[0].valid = in_tvalid;
    chain[0].sgn   = ah[63] ^ bh[63];
    chain[0].zero  = (ah[62:48] == '0) || (bh[62:48] == '0);
    chain[0].esum  = {1'b0, ah[62:48]} + {1'b0, bh[62:48]};
    chain[0].sa    = {1'b1, ah[47:0], al};
    chain[0].sb    = {1'b1, bh[47:0], bl};
    chain[0].acc   = '0;
  end

  for (genvar k = 0; k < qfm_pkg::NCELL; k++) begin : g_cell
    qfm_cell #(
      .LIMB_A(k / qfm_pkg::NLIMB),
      .LIMB_B(k % qfm_pkg::NLIMB)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (advance),
      .stage_in (chain[k]),
      .stage_out(chain[k+1])
    );
  end

  qfm_norm u_norm (
    .stage_in(chain[qfm_pkg::NCELL]),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= chain[qfm_pkg::NCELL].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.product_low, res_r.product_high};
  assign out_tuser  = {res_r.underflow_flag, res_r.overflow_flag};

endmodule
`default_nettype wire

/* hw/rtl/qfm_checker.sv */
// Port-level assertions for the binary128 multiplier and their binding.
`default_nettype none
module qfm_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [127:0] out_tdata,
  input wire logic [1:0]   out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("Stalled output transaction changed.");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("Input ready does not follow output backpressure.");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("Overflow and underflow raised together.");

  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[62:48] == 15'h7FFF && out_tdata[47:0] == '0
      && out_tdata[127:64] == '0)
    else $error("Overflow result is not infinity.");

  a_unf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata[62:0] == '0 && out_tdata[127:64] == '0)
    else $error("Underflow result is not zero.");

endmodule

bind quad_float_multiply qfm_checker u_qfm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
`default_nettype wire

/* dv/qfm_checker.sv */
// Checker that predicts binary128 products and compares them with the output channel.
`timescale 1ns / 1ps
module qfm_scoreboard (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [255:0] in_tdata,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [127:0] out_tdata,
  input  wire logic [1:0]   out_tuser,
  output int                fail_count,
  output int                pending_count,
  output int                product_count
);

  qfm_pkg::result_t expected_products[$];

  function automatic qfm_pkg::result_t multiply_quad(input logic [255:0] pair);
    logic [63:0] a_hi, a_lo, b_hi, b_lo;
    logic [qfm_pkg::SIG_W-1:0] sig_a, sig_b;
    logic [qfm_pkg::PROD_W-1:0] full;
    logic [qfm_pkg::FRAC_W-1:0] frac;
    logic sgn, top;
    int exp_a, exp_b, exp_c;
    qfm_pkg::result_t r;
    a_hi = pair[63:0];
    a_lo = pair[127:64];
    b_hi = pair[191:128];
    b_lo = pair[255:192];
    sgn = a_hi[63] ^ b_hi[63];
    exp_a = a_hi[62:48];
    exp_b = b_hi[62:48];
    r = '0;
    r.product_high[63] = sgn;
    if (exp_a == 0 || exp_b == 0) return r;
    sig_a = {1'b1, a_hi[47:0], a_lo};
    sig_b = {1'b1, b_hi[47:0], b_lo};
    full = qfm_pkg::PROD_W'(sig_a) * qfm_pkg::PROD_W'(sig_b);
    top = full[qfm_pkg::PROD_W-1];
    exp_c = exp_a + exp_b - int'(qfm_pkg::EXP_BIAS) + int'(top);
    if (exp_c >= int'(qfm_pkg::EXP_MAX)) begin
      r.product_high[62:48] = qfm_pkg::EXP_MAX;
      r.overflow_flag = 1'b1;
      return r;
    end
    if (exp_c <= 0) begin
      r.underflow_flag = 1'b1;
      return r;
    end
    frac = top ? full[224:113] : full[223:112];
    r.product_high[62:48] = exp_c[14:0];
    r.product_high[47:0] = frac[111:64];
    r.product_low = frac[63:0];
    return r;
  endfunction

  assign pending_count = expected_products.size();

  always @(posedge clk) begin
    qfm_pkg::result_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
      product_count <= 0;
    end else begin
      if (in_tvalid && in_tready) expected_products.push_back(multiply_quad(in_tdata));
      if (out_tvalid && out_tready) begin
        product_count <= product_count + 1;
        if (expected_products.size() == 0) begin
          $error("product transaction with nothing expected");
          errs = errs + 1;
        end else begin
          want = expected_products.pop_front();
          if (out_tdata[63:0] !== want.product_high) begin
            $error("product_high expected %h got %h", want.product_high, out_tdata[63:0]);
            errs = errs + 1;
          end
          if (out_tdata[127:64] !== want.product_low) begin
            $error("product_low expected %h got %h", want.product_low, out_tdata[127:64]);
            errs = errs + 1;
          end
          if (out_tuser[0] !== want.overflow_flag) begin
            $error("overflow_flag expected %b got %b", want.overflow_flag, out_tuser[0]);
            errs = errs + 1;
          end
          if (out_tuser[1] !== want.underflow_flag) begin
            $error("underflow_flag expected %b got %b", want.underflow_flag, out_tuser[1]);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

/* dv/tb.sv */
// Testbench top that drives operand pairs into the binary128 multiplier and reports the verdict.
`timescale 1ns / 1ps
module tb;
  localparam int RANDOM_PAIRS = 2000;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [255:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic [1:0] out_tuser;
  int fail_count, pending_count, product_count;
  int cycle_count = 0;
  int hold_off = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quad_float_multiply dut (.*);
  qfm_scoreboard checker_i (.*);

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] make_high(input logic s, input logic [14:0] e,
                                            input logic [47:0] f);
    return {s, e, f};
  endfunction

  function automatic logic [14:0] rand_exp();
    case ($urandom_range(0, 9))
      0: return 15'h0;
      1: return 15'h7FFF;
      2: return 15'($urandom_range(1, 200));
      3: return 15'($urandom_range(16'h7F00, 16'h7FFE));
      default: return 15'($urandom_range(16'h2000, 16'h5FFF));
    endcase
  endfunction

  task automatic send_pair(input logic [63:0] ah, input logic [63:0] al,
                           input logic [63:0] bh, input logic [63:0] bl);
    in_tdata <= {bl, bh, al, ah};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic take_gap();
    if ($urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // The receiver stalls on its own pattern, with one long hold-off mid-run.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else if (product_count == 600 && out_tvalid && out_tready) begin
      hold_off <= 80;
      out_tready <= 1'b0;
    end else if ((cycle_count / 300) % 3 == 0) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    logic [63:0] ones;
    ones = '1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_pair('0, '0, '0, '0);
    send_pair(ones, ones, ones, ones);
    send_pair(make_high(0, 15'h3FFF, 0), 0, make_high(1, 15'h3FFF, 0), 0);
    send_pair(make_high(0, 15'h3FFF, '1), ones, make_high(0, 15'h3FFF, '1), ones);
    send_pair(make_high(1, 15'h0, '1), ones, make_high(0, 15'h4000, 5), 7);
    send_pair(make_high(0, 15'h5000, 0), 1, make_high(1, 15'h0, 0), 0);
    send_pair(make_high(0, 15'h7FFE, 0), 0, make_high(0, 15'h4000, 0), 0);
    send_pair(make_high(1, 15'h7FFF, 0), 0, make_high(0, 15'h3FFF, 0), 0);
    send_pair(make_high(0, 15'h7FFF, '1), ones, make_high(1, 15'h7FFF, 0), 0);
    send_pair(make_high(0, 15'h0001, 0), 0, make_high(0, 15'h0001, 0), 0);
    send_pair(make_high(1, 15'h2000, 0), 0, make_high(0, 15'h1FFF, 0), 0);
    send_pair(make_high(0, 15'h2000, 0), 0, make_high(0, 15'h2000, 0), 0);
    send_pair(make_high(0, 15'h3FFF, '1), ones, make_high(0, 15'h4000, 0), 0);
    send_pair(make_high(0, 15'h7FFF, '1), ones, make_high(0, 15'h0001, '1), ones);
    send_pair(make_high(0, 15'h5FFF, '1), ones, make_high(0, 15'h5FFF, '1), ones);
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      logic [63:0] ah, bh;
      ah = rand64();
      bh = rand64();
      if ($urandom_range(0, 1)) ah[62:48] = rand_exp();
      if ($urandom_range(0, 1)) bh[62:48] = rand_exp();
      send_pair(ah, rand64(), bh, rand64());
      if (n % 200 > 120) take_gap();
    end
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d operand pairs: zero, overflow, underflow, max-exponent and random cases.",
             RANDOM_PAIRS + 15);
    $display("Checked %0d products under random and long output stalls.", product_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
